// ----- hdl/bni_pkg.sv -----
// Shared constants and types for the batch normalization inference unit.
package bni_pkg;
    localparam int MaxChannelsDefault = 256;
    localparam int DataWidth          = 32;
    localparam int ChanWidth          = 8;

    localparam logic [1:0] RegChannelCount  = 2'd0;
    localparam logic [1:0] RegSpatialLength = 2'd1;
    localparam logic [1:0] RegEpsilon       = 2'd2;

    localparam logic OpSample = 1'b0;
    localparam logic OpLoad   = 1'b1;

    // Folded coefficients stored per channel.
    typedef struct packed {
        logic signed [31:0] factor;
        logic signed [31:0] mean;
        logic signed [31:0] bias;
    } t_coef;
endpackage

// ----- hdl/bni_fold.sv -----
// Multi-cycle unit: factor = scale * 2^16 / sqrt((variance + epsilon) * 2^16).
module bni_fold
    import bni_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_scale,
    input  logic [30:0]        i_variance,
    input  logic [15:0]        i_epsilon,
    output logic               o_done,
    output logic signed [31:0] o_factor
);
    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIV, S_FIN} t_state;

    t_state       r_state;
    logic [47:0]  r_rem;     // radicand remainder
    logic [47:0]  r_rad;     // radicand shifting out
    logic [23:0]  r_root;
    logic [5:0]   r_cnt;
    logic [47:0]  r_num;
    logic [48:0]  r_drem;
    logic [47:0]  r_quot;
    logic         r_neg;
    logic         r_done;
    logic signed [31:0] r_factor;

    logic [49:0]  rem_sh;
    logic [49:0]  trial;
    logic [48:0]  drem_sh;
    logic [31:0]  sc_mag;

    always_comb begin
        sc_mag  = i_scale[31] ? 32'(-i_scale) : 32'(i_scale);
        rem_sh  = {r_rem, r_rad[47:46]};
        trial   = {24'd0, r_root, 2'b01};
        drem_sh = {r_drem[47:0], r_num[47]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rad   <= {(32'({1'b0, i_variance}) + 32'(i_epsilon)), 16'd0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 6'd24;
                        r_num   <= {sc_mag, 16'd0};
                        r_neg   <= i_scale[31];
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // one root bit per cycle
                    if (rem_sh >= trial) begin
                        r_rem  <= 48'(rem_sh - trial);
                        r_root <= {r_root[22:0], 1'b1};
                    end else begin
                        r_rem  <= 48'(rem_sh);
                        r_root <= {r_root[22:0], 1'b0};
                    end
                    r_rad <= {r_rad[45:0], 2'b00};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_cnt   <= 6'd48;
                        r_drem  <= '0;
                        r_quot  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (r_root != 24'd0 && drem_sh >= {25'd0, r_root}) begin
                        r_drem <= drem_sh - {25'd0, r_root};
                        r_quot <= {r_quot[46:0], 1'b1};
                    end else begin
                        r_drem <= drem_sh;
                        r_quot <= {r_quot[46:0], 1'b0};
                    end
                    r_num <= {r_num[46:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_root == 24'd0) begin
                        if (r_num == 48'd0 && !r_neg && r_quot == 48'd0)
                            r_factor <= '0;
                        else
                            r_factor <= 32'h7FFF_FFFF;
                    end else if (r_neg) begin
                        r_factor <= (r_quot >= 48'h8000_0000) ? 32'h8000_0000
                                                             : 32'(-r_quot[31:0]);
                    end else begin
                        r_factor <= (r_quot > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                            : r_quot[31:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // zero root: sign of scale picks the rail, zero scale gives zero
    logic zero_scale;
    logic [47:0] r_mag0;
    always_ff @(posedge i_clk) begin
        if (i_start && r_state == S_IDLE) r_mag0 <= {sc_mag, 16'd0};
    end
    assign zero_scale = (r_mag0 == 48'd0);

    assign o_done   = r_done;
    assign o_factor = (r_root == 24'd0) ?
                      (zero_scale ? 32'sd0 : (r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF))
                      : r_factor;
endmodule

// ----- hdl/batch_norm_inference_unit.sv -----
// Top level of the batch normalization inference unit.
// Input channel: i_valid / o_stall with operation, channel and parameters or a
// sample. operation = load folds scale/sqrt(variance+epsilon) and writes one
// coefficient word into the table; it emits no result. operation = sample
// reads the channel's coefficients and emits one output word.
// Output channel: o_valid / i_stall with normalized value, channel, saturated.
// Configuration: i_cfg_valid / o_cfg_ready, index and data; write only when idle.
// A sample passes through table read, subtract, multiply and shift/add/clamp
// before its word is registered; samples are taken one at a time, since the
// input stays stalled until the output word is taken. A load blocks the input
// through start, 24 root steps, 48 quotient steps, finish and table write.
// Reset clears counters and control; the coefficient table holds garbage
// until each channel is loaded. When the receiver stalls the result word
// holds in the output register and no new item is taken.
module batch_norm_inference_unit
    import bni_pkg::*;
#(
    parameter int MAX_CHANNELS = MaxChannelsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [7:0]         i_channel,
    input  logic signed [31:0] i_scale,
    input  logic signed [31:0] i_bias,
    input  logic signed [31:0] i_mean,
    input  logic [30:0]        i_variance,
    input  logic signed [31:0] i_sample_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_normalized_value,
    output logic [7:0]         o_sample_channel,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ChanLim = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    typedef enum logic [2:0] {S_IDLE, S_FOLD, S_RD, S_SUB, S_MUL, S_OUT} t_state;

    t_coef r_mem [MAX_CHANNELS];
    t_coef r_rd;

    t_state       r_state;
    logic [8:0]   r_ccount;
    logic [23:0]  r_slen;
    logic [15:0]  r_eps;
    logic [23:0]  r_pos;
    logic [7:0]   r_chan;
    logic [7:0]   r_cur;
    logic [7:0]   r_ld_chan;
    logic         r_ld_ok;
    logic signed [31:0] r_ld_bias, r_ld_mean, r_x;
    logic signed [32:0] r_d;
    logic signed [63:0] r_p;
    logic signed [31:0] r_out;
    logic         r_sat, r_ovalid;
    logic [7:0]   r_och;

    logic         fold_start, fold_done;
    logic signed [31:0] fold_factor;
    logic         acc;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [23:0]  n_pos, len;
    logic [8:0]   n_chan, lim;
    logic signed [47:0] sh;
    logic signed [48:0] sum;

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign acc         = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign fold_start  = acc && i_operation == OpLoad;

    bni_fold u_fold (
        .i_clk, .i_rst_n, .i_start(fold_start), .i_scale, .i_variance,
        .i_epsilon(r_eps), .o_done(fold_done), .o_factor(fold_factor)
    );

    always_comb begin
        rd_addr = (32'(r_chan) >= MAX_CHANNELS) ? '0 : AW'(r_chan);
        wr_addr = AW'(r_ld_chan);
        len = (r_slen == 24'd0) ? 24'd1 : r_slen;
        lim = (r_ccount == 9'd0) ? 9'd1 :
              (r_ccount > 9'(ChanLim)) ? 9'(ChanLim) : r_ccount;
        n_pos  = r_pos + 24'd1;
        n_chan = 9'(r_chan) + 9'd1;
        sh  = 48'(r_p >>> 16);
        sum = 49'(sh) + 49'(r_rd.bias);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FOLD && fold_done && r_ld_ok)
            r_mem[wr_addr] <= '{factor: fold_factor, mean: r_ld_mean, bias: r_ld_bias};
        if (r_state == S_RD) r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ccount <= 9'd1;
            r_slen   <= 24'd1;
            r_eps    <= 16'd1;
            r_pos    <= '0;
            r_chan   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegChannelCount: begin
                        r_ccount <= i_cfg_data[8:0];
                        r_pos <= '0; r_chan <= '0;
                    end
                    RegSpatialLength: begin
                        r_slen <= i_cfg_data[23:0];
                        r_pos <= '0; r_chan <= '0;
                    end
                    RegEpsilon: r_eps <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_operation == OpLoad) begin
                            r_ld_chan <= i_channel;
                            r_ld_ok   <= 32'(i_channel) < MAX_CHANNELS;
                            r_ld_bias <= i_bias;
                            r_ld_mean <= i_mean;
                            r_state   <= S_FOLD;
                        end else begin
                            r_x     <= i_sample_value;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FOLD: if (fold_done) r_state <= S_IDLE;
                S_RD: begin
                    r_cur <= (32'(r_chan) >= MAX_CHANNELS) ? 8'd0 : r_chan;
                    // advance position and channel counters
                    if (n_pos >= len || n_pos == 24'd0) begin
                        r_pos  <= '0;
                        r_chan <= (n_chan >= lim || n_chan[7:0] == 8'd0) ? 8'd0
                                                                        : n_chan[7:0];
                    end else begin
                        r_pos <= n_pos;
                    end
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_d     <= 33'(r_x) - 33'(r_rd.mean);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p     <= 64'(r_rd.factor) * 64'(r_d);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (sum > 49'sh7FFF_FFFF) begin
                        r_out <= 32'sh7FFF_FFFF; r_sat <= 1'b1;
                    end else if (sum < -49'sh8000_0000) begin
                        r_out <= 32'sh8000_0000; r_sat <= 1'b1;
                    end else begin
                        r_out <= sum[31:0]; r_sat <= 1'b0;
                    end
                    r_och    <= r_cur;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_normalized_value = r_out;
    assign o_sample_channel   = r_och;
    assign o_saturated        = r_sat;
endmodule

// ----- sim/batch_norm_inference_unit_tb.sv -----
// Self-checking testbench for the batch normalization inference unit.
`timescale 1ns / 100ps

module batch_norm_inference_unit_tb
    import bni_pkg::*;
;

    localparam int IdleLimit = 20000;
    localparam logic [1:0] RegUnknown = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_operation;
    logic [7:0]         i_channel;
    logic signed [31:0] i_scale;
    logic signed [31:0] i_bias;
    logic signed [31:0] i_mean;
    logic [30:0]        i_variance;
    logic signed [31:0] i_sample_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_normalized_value;
    logic [7:0]         o_sample_channel;
    logic               o_saturated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    batch_norm_inference_unit dut (.*);

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         chan;
        logic               sat;
    } t_norm;

    // predictor state
    logic signed [31:0] factor_mem [256];
    logic signed [31:0] mean_mem   [256];
    logic signed [31:0] bias_mem   [256];
    bit                 loaded     [256];
    logic [23:0]        pos_cnt;
    logic [7:0]         chan_cnt;
    logic [8:0]         num_chans;
    logic [23:0]        span_len;
    logic [15:0]        eps;

    t_norm  expected_q [$];
    int     errors;
    int     idle_cycles;
    bit     quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fold(input logic signed [31:0] sc,
                                                input logic [30:0] var_in);
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] q;
        root = int_sqrt(({33'd0, var_in} + eps) << 16);
        mag = sc < 0 ? 64'(-64'(sc)) : 64'(sc);
        if (root == 0) begin
            if (mag == 0) return 0;
            return sc < 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        q = (mag << 16) / root;
        if (sc < 0) return q >= 64'h8000_0000 ? 32'sh8000_0000 : 32'(-64'(q));
        return q > 64'h7fff_ffff ? 32'sh7fff_ffff : 32'(q);
    endfunction

    // Update the predictor for one accepted word.
    task automatic predict_norm(input logic op, input logic [7:0] ch,
                                input logic signed [31:0] sc, bi, mn,
                                input logic [30:0] vr, input logic signed [31:0] x);
        longint d;
        longint p;
        longint s;
        t_norm  r;
        int     lim;
        if (op == OpLoad) begin
            factor_mem[ch] = fold(sc, vr);
            bias_mem[ch] = bi;
            mean_mem[ch] = mn;
            loaded[ch] = 1'b1;
            return;
        end
        d = longint'(x) - longint'(mean_mem[chan_cnt]);
        p = longint'(factor_mem[chan_cnt]) * d;
        p = p >>> 16;
        s = p + longint'(bias_mem[chan_cnt]);
        r.sat = 1'b0;
        if (s > 64'sd2147483647) begin
            s = 64'sd2147483647;
            r.sat = 1'b1;
        end else if (s < -64'sd2147483648) begin
            s = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = 32'(s);
        r.chan = chan_cnt;
        expected_q.push_back(r);
        lim = num_chans == 0 ? 1 : (num_chans > 256 ? 256 : num_chans);
        pos_cnt = pos_cnt + 24'd1;
        if (pos_cnt >= (span_len == 0 ? 24'd1 : span_len) || pos_cnt == 0) begin
            pos_cnt = 0;
            chan_cnt = chan_cnt + 8'd1;
            if (chan_cnt >= lim || chan_cnt == 0) chan_cnt = 0;
        end
    endtask

    task automatic send_word(input logic op, input logic [7:0] ch,
                             input logic signed [31:0] sc, bi, mn,
                             input logic [30:0] vr, input logic signed [31:0] x);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_channel      <= ch;
        i_scale        <= sc;
        i_bias         <= bi;
        i_mean         <= mn;
        i_variance     <= vr;
        i_sample_value <= x;
        do @(posedge i_clk); while (o_stall);
        predict_norm(op, ch, sc, bi, mn, vr, x);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_load(input logic [7:0] ch, input logic signed [31:0] sc, bi, mn,
                             input logic [30:0] vr);
        send_word(OpLoad, ch, sc, bi, mn, vr, $urandom);
    endtask

    task automatic send_sample(input logic signed [31:0] x);
        send_word(OpSample, 8'($urandom), $urandom, $urandom, $urandom, 31'($urandom), x);
    endtask

    // Drain results, then let a possible fold finish before touching registers.
    task automatic wait_idle();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegChannelCount: begin
                num_chans = data[8:0];
                pos_cnt = 0;
                chan_cnt = 0;
            end
            RegSpatialLength: begin
                span_len = data[23:0];
                pos_cnt = 0;
                chan_cnt = 0;
            end
            RegEpsilon: eps = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            3: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_variance();
        case ($urandom_range(0, 4))
            0: return 31'h0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(0, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    // Load channels that are still empty, and reload some at random, so samples never read garbage.
    task automatic load_geometry(input int nch);
        for (int c = 0; c < nch; c++)
            if (!loaded[c] || $urandom_range(0, 3) == 0)
                send_load(8'(c), rand_value(), rand_value(), rand_value(), rand_variance());
    endtask

    task automatic test_directed();
        write_reg(RegEpsilon, 32'd0);
        write_reg(RegChannelCount, 32'd3);
        write_reg(RegSpatialLength, 32'd2);
        send_load(8'd0, 32'sh0001_0000, 32'sh0, 32'sh0, 31'h0001_0000);
        send_load(8'd1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 31'h0);
        send_load(8'd2, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 31'h0);
        send_load(8'd255, 32'sh0, 32'sh1234_5678, 32'sh0, 31'h7fff_ffff);
        send_sample(32'sh0002_8000);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7fff_ffff);
        send_sample(32'shffff_ffff);
        wait_idle();
        // zero scale on zero root, with channel count 256 and spatial length 0
        write_reg(RegChannelCount, 32'd256);
        write_reg(RegSpatialLength, 32'd0);
        send_load(8'd0, 32'sh0, 32'sh0000_0100, 32'sh0, 31'h0);
        send_sample(32'sh1234_5678);
        wait_idle();
        write_reg(RegChannelCount, 32'd0);
        write_reg(RegEpsilon, 32'd65535);
        send_load(8'd0, 32'shffff_0000, 32'sh0, 32'sh0, 31'h7fff_ffff);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        wait_idle();
    endtask

    task automatic test_random_phase(input int nch, input int span, input int eps_val,
                                     input int n_items);
        write_reg(RegEpsilon, eps_val);
        write_reg(RegChannelCount, nch);
        write_reg(RegSpatialLength, span);
        load_geometry(nch > 256 ? 256 : (nch == 0 ? 1 : nch));
        for (int k = 0; k < n_items; k++) send_sample(rand_value());
        wait_idle();
    endtask

    task automatic test_unknown_index();
        write_reg(RegUnknown, $urandom);
        send_sample(rand_value());
        wait_idle();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word value=%0d", o_normalized_value);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_normalized_value !== e.value) begin
                    $error("normalized_value expected %0d actual %0d",
                           e.value, o_normalized_value);
                    errors++;
                end
                if (o_sample_channel !== e.chan) begin
                    $error("sample_channel expected %0d actual %0d",
                           e.chan, o_sample_channel);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated expected %0b actual %0b", e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OpSample;
        i_channel = 0;
        i_scale = 0;
        i_bias = 0;
        i_mean = 0;
        i_variance = 0;
        i_sample_value = 0;
        i_cfg_valid = 1'b0;
        i_cfg_index = RegChannelCount;
        i_cfg_data = 0;
        pos_cnt = 0;
        chan_cnt = 0;
        num_chans = 1;
        span_len = 1;
        eps = 1;
        for (int c = 0; c < 256; c++) loaded[c] = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed();
        test_unknown_index();
        test_random_phase(1, 1, 1, 60);
        test_random_phase(4, 3, 0, 120);
        test_random_phase(5, 16_777_215, 65535, 90);
        test_random_phase(256, 1, 300, 200);
        test_random_phase(300, 2, $urandom_range(0, 65535), 40);
        quiet = 1'b1;
        test_random_phase(7, 5, $urandom_range(0, 65535), 100);

        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
